// ===== rtl/tws_pkg.sv =====
// Package: shared constants, codes and types of the tick task wake scheduler.
package tws_pkg;

   localparam int NumSlots = 8;
   localparam int SlotW    = 3;
   localparam int TickW    = 32;
   localparam int OpW      = 2;
   localparam int StatusW  = 2;

   typedef enum logic [OpW-1:0] {
      OP_CREATE  = 2'd0,
      OP_SCAN    = 2'd1,
      OP_DELAY   = 2'd2,
      OP_ADVANCE = 2'd3
   } op_type;

   localparam logic [StatusW-1:0] ST_OK     = 2'd0;
   localparam logic [StatusW-1:0] ST_FULL   = 2'd1;
   localparam logic [StatusW-1:0] ST_UNUSED = 2'd2;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [SlotW-1:0]   slot_index;
      logic               due;
      logic               last;
      logic [TickW-1:0]   tick_now;
   } rsp_word_type;

   typedef struct packed {
      logic             en;
      logic [SlotW-1:0] addr;
      logic [TickW-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [SlotW-1:0] addr;
   } ram_rd_type;

endpackage

// ===== rtl/tws_chan_if.sv =====
// Interfaces: request and response channels with valid/ready handshake.
interface tws_req_if;
   logic                          valid;
   logic                          ready;
   logic [tws_pkg::OpW-1:0]       op;
   logic [tws_pkg::SlotW-1:0]     slot;
   logic [tws_pkg::TickW-1:0]     ticks;

   modport source (output valid, output op, output slot, output ticks, input ready);
   modport sink   (input valid, input op, input slot, input ticks, output ready);
endinterface

interface tws_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [tws_pkg::StatusW-1:0]   status;
   logic [tws_pkg::SlotW-1:0]     slot_index;
   logic                          due;
   logic                          last;
   logic [tws_pkg::TickW-1:0]     tick_now;

   modport source (output valid, output status, output slot_index, output due,
                   output last, output tick_now, input ready);
   modport sink   (input valid, input status, input slot_index, input due,
                   input last, input tick_now, output ready);
endinterface

// ===== rtl/tick_task_wake_scheduler_core.sv =====
// Top level: cooperative tick scheduler with slot table, wake memory and tick count.
// Create, delay and advance are each handled in the idle state and give one
// result word. A scan walks the slot table one slot per cycle through the wake
// memory's single read port, except while a due slot's word waits for the sink
// to drain the output register; the final word likewise waits for the output
// register to be free. A request is taken only when the block is idle and the
// output register is free or being drained in the same cycle. Wake ticks live
// in a synchronous memory; used marks are flip-flops, so the table needs no
// clearing pass after reset.
module tick_task_wake_scheduler_core (
   input logic       clock,
   input logic       reset,
   tws_req_if.sink   req_bus,
   tws_rsp_if.source rsp_bus
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CHK  = 3'b010,
      S_END  = 3'b100
   } state_type;

   localparam logic [tws_pkg::SlotW-1:0] LastIdx = tws_pkg::SlotW'(tws_pkg::NumSlots - 1);

   state_type                          state_ff, state_in;
   logic [tws_pkg::NumSlots-1:0]       used_ff, used_in;
   logic [tws_pkg::TickW-1:0]          tick_ff, tick_in;
   logic [tws_pkg::SlotW-1:0]          idx_ff, idx_in;
   logic                               pend_ff, pend_in;
   logic [tws_pkg::SlotW-1:0]          pend_idx_ff, pend_idx_in;

   tws_pkg::ram_wr_type                ram_wr;
   tws_pkg::ram_rd_type                ram_rd;
   logic [tws_pkg::TickW-1:0]          ram_rdata;
   tws_pkg::rsp_word_type              word;
   logic                               load;
   logic                               out_free;

   logic                               req_acc;
   logic [tws_pkg::TickW-1:0]          amt;
   logic [tws_pkg::TickW-1:0]          diff;
   logic                               due_now;
   logic                               stall;
   logic                               free_any;
   logic [tws_pkg::SlotW-1:0]          free_idx;

   assign req_bus.ready = (state_ff == S_IDLE) && out_free;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign amt           = (req_bus.ticks == '0) ? tws_pkg::TickW'(1) : req_bus.ticks;
   assign diff          = tick_ff - ram_rdata;
   assign due_now       = used_ff[idx_ff] && !diff[tws_pkg::TickW-1];
   assign stall         = due_now && pend_ff && !out_free;

   // lowest free slot
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = tws_pkg::NumSlots - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_any = 1'b1;
            free_idx = tws_pkg::SlotW'(i);
         end
      end
   end

   always_comb begin
      state_in         = state_ff;
      used_in          = used_ff;
      tick_in          = tick_ff;
      idx_in           = idx_ff;
      pend_in          = pend_ff;
      pend_idx_in      = pend_idx_ff;
      ram_wr           = '0;
      ram_rd           = '0;
      load             = 1'b0;
      word             = '0;
      word.status      = tws_pkg::ST_OK;
      word.last        = 1'b1;
      word.tick_now    = tick_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (tws_pkg::op_type'(req_bus.op))
                  tws_pkg::OP_CREATE: begin
                     load = 1'b1;
                     if (free_any) begin
                        used_in[free_idx] = 1'b1;
                        ram_wr            = '{en: 1'b1, addr: free_idx, data: '0};
                        word.slot_index   = free_idx;
                     end else begin
                        word.status = tws_pkg::ST_FULL;
                     end
                  end
                  tws_pkg::OP_SCAN: begin
                     ram_rd   = '{en: 1'b1, addr: '0};
                     idx_in   = '0;
                     pend_in  = 1'b0;
                     state_in = S_CHK;
                  end
                  tws_pkg::OP_DELAY: begin
                     load = 1'b1;
                     if (used_ff[req_bus.slot]) begin
                        ram_wr = '{en: 1'b1, addr: req_bus.slot, data: tick_ff + amt};
                     end else begin
                        word.status = tws_pkg::ST_UNUSED;
                     end
                  end
                  tws_pkg::OP_ADVANCE: begin
                     load          = 1'b1;
                     tick_in       = tick_ff + amt;
                     word.tick_now = tick_ff + amt;
                  end
               endcase
            end
         end
         S_CHK: begin
            if (!stall) begin
               if (due_now) begin
                  ram_wr = '{en: 1'b1, addr: idx_ff, data: tick_ff + tws_pkg::TickW'(1)};
                  // emit the previous due slot; it is not the final one
                  if (pend_ff) begin
                     load            = 1'b1;
                     word.slot_index = pend_idx_ff;
                     word.due        = 1'b1;
                     word.last       = 1'b0;
                  end
                  pend_in     = 1'b1;
                  pend_idx_in = idx_ff;
               end
               if (idx_ff == LastIdx) begin
                  state_in = S_END;
               end else begin
                  idx_in = idx_ff + tws_pkg::SlotW'(1);
                  ram_rd = '{en: 1'b1, addr: idx_ff + tws_pkg::SlotW'(1)};
               end
            end
         end
         S_END: begin
            if (out_free) begin
               load = 1'b1;
               if (pend_ff) begin
                  word.slot_index = pend_idx_ff;
                  word.due        = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
         tick_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
         tick_ff  <= tick_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      pend_idx_ff <= pend_idx_in;
   end

   tws_wake_ram u_wake_ram (
      .clock (clock),
      .wr    (ram_wr),
      .rd    (ram_rd),
      .rdata (ram_rdata)
   );

   tws_rsp_reg u_rsp_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (load),
      .word    (word),
      .free    (out_free),
      .rsp_bus (rsp_bus)
   );

`ifndef SYNTHESIS
   a_scan_start : assert property (@(posedge clock) disable iff (reset)
      req_acc && (req_bus.op == tws_pkg::OP_SCAN) |=> (state_ff == S_CHK) && (idx_ff == '0))
      else $error("scan did not start at slot zero");

   a_no_write_on_stall : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) && stall |-> !ram_wr.en && !load)
      else $error("scan wrote or emitted while stalled");

   a_scan_write_used : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK) && ram_wr.en |-> used_ff[ram_wr.addr])
      else $error("scan rewrote an unused slot");

   a_scan_end_last : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_END) && out_free |=> rsp_bus.valid && rsp_bus.last)
      else $error("scan end gave no final word");
`endif

endmodule

// ===== rtl/tws_wake_ram.sv =====
// Wake tick memory: one write port, one read port with registered read data.
module tws_wake_ram (
   input  logic                      clock,
   input  tws_pkg::ram_wr_type       wr,
   input  tws_pkg::ram_rd_type       rd,
   output logic [tws_pkg::TickW-1:0] rdata
);

   logic [tws_pkg::TickW-1:0] wake_mem_ff [tws_pkg::NumSlots];
   logic [tws_pkg::TickW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         wake_mem_ff[wr.addr] <= wr.data;
      end
   end

   // hold read data while no read is issued
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_ff <= wake_mem_ff[rd.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/tws_rsp_reg.sv =====
// Response output register: holds one result word until the sink takes it.
module tws_rsp_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  tws_pkg::rsp_word_type word,
   output logic                  free,
   tws_rsp_if.source             rsp_bus
);

   logic                  valid_ff;
   logic                  valid_in;
   tws_pkg::rsp_word_type word_ff;

   assign free     = !valid_ff || rsp_bus.ready;
   assign valid_in = load || (valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word;
      end
   end

   assign rsp_bus.valid      = valid_ff;
   assign rsp_bus.status     = word_ff.status;
   assign rsp_bus.slot_index = word_ff.slot_index;
   assign rsp_bus.due        = word_ff.due;
   assign rsp_bus.last       = word_ff.last;
   assign rsp_bus.tick_now   = word_ff.tick_now;

endmodule
